// ===== hdl/ethernet_ipv4_header_classifier_unit_macros.svh =====
// ----------------------------------------------------------------------------
// ethernet ipv4 header classifier assertion macros
// shared property forms for the checker, clocked with reset disable
// ----------------------------------------------------------------------------
`ifndef ETHERNET_IPV4_HEADER_CLASSIFIER_UNIT_MACROS_SVH
`define ETHERNET_IPV4_HEADER_CLASSIFIER_UNIT_MACROS_SVH

// same-cycle implication
`define EHC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EHC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ehc_pkg.sv =====
// ----------------------------------------------------------------------------
// ehc_pkg
// types and constants shared by the ethernet ipv4 header classifier
// ----------------------------------------------------------------------------
package ehc_pkg;

    localparam int MAX_FRAME_DEF = 2048;

    localparam int SNAP_W   = 12;
    localparam int DATA_W   = 8;
    localparam int CLASS_W  = 3;
    localparam int RESULT_W = 168;

    localparam logic [SNAP_W-1:0] SNAP_RESET = 12'd2048;

    localparam int ETH_HDR  = 14;
    localparam int IPV4_MIN = 20;
    localparam int TCP_MIN  = 20;
    localparam int UDP_HDR  = 8;

    // byte offsets within the frame
    localparam int POS_ETYPE_HI = 12;
    localparam int POS_ETYPE_LO = 13;
    localparam int POS_IHL      = 14;
    localparam int POS_PROTO    = 23;
    localparam int POS_SRC_LO   = 26;
    localparam int POS_SRC_HI   = 29;
    localparam int POS_DST_LO   = 30;
    localparam int POS_DST_HI   = 33;

    // byte offsets within the layer-4 header
    localparam int L4_PORT_LAST = 3;
    localparam int L4_OFFS_BYTE = 12;
    localparam int L4_FLAG_BYTE = 13;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef enum logic [CLASS_W-1:0] {
        CLS_SHORT = 3'd0,
        CLS_TCP   = 3'd1,
        CLS_UDP   = 3'd2,
        CLS_ICMP  = 3'd3,
        CLS_IPV4  = 3'd4,
        CLS_ARP   = 3'd5,
        CLS_OTHER = 3'd6
    } t_pkt_class;

    // header fields captured while a frame streams in
    typedef struct packed {
        logic [15:0] type_reg;
        logic [3:0]  header_words;
        logic [7:0]  proto_reg;
        logic [31:0] src_addr_reg;
        logic [31:0] dst_addr_reg;
        logic [31:0] port_pair_reg;
        logic [15:0] l4_bytes_reg;
        logic [3:0]  tcp_offset_reg;
    } t_ehc_hdr;

    // one classification record
    typedef struct packed {
        t_pkt_class  packet_class;
        logic [15:0] ether_type;
        logic [11:0] frame_length;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [7:0]  ip_proto;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  tcp_flag_bits;
        logic [7:0]  icmp_type_code;
        logic [7:0]  icmp_code_byte;
        logic [11:0] payload_length;
    } t_ehc_rec;

endpackage

// ===== hdl/ehc_capture.sv =====
// ----------------------------------------------------------------------------
// ehc_capture
// counts kept frame bytes and latches the header fields byte by byte
// ----------------------------------------------------------------------------
module ehc_capture #(
    parameter int MAX_FRAME = ehc_pkg::MAX_FRAME_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_take,
    input  logic [ehc_pkg::DATA_W-1:0]       i_byte,
    input  logic                             i_last,
    input  logic [ehc_pkg::SNAP_W-1:0]       i_snap_length,
    output ehc_pkg::t_ehc_hdr                o_hdr,
    output logic [$clog2(MAX_FRAME+1)-1:0]   o_len
);
    import ehc_pkg::*;

    localparam int PW = $clog2(MAX_FRAME + 1);

    logic [PW-1:0] r_pos;
    t_ehc_hdr      r_hdr;

    logic [PW-1:0] n_pos;
    t_ehc_hdr      n_hdr;
    logic          snap_small;
    logic [PW-1:0] limit;
    logic          keep;
    logic [3:0]    hw_eff;
    logic [PW-1:0] l4_start;
    logic [PW-1:0] rel;
    logic          in_l4;

    always_comb begin
        snap_small = (i_snap_length != '0) && (32'(i_snap_length) < 32'(MAX_FRAME));
        limit      = snap_small ? PW'(i_snap_length) : PW'(MAX_FRAME);
        keep       = r_pos < limit;

        // the ihl byte itself already moves the layer-4 start
        hw_eff   = (r_pos == PW'(POS_IHL)) ? i_byte[3:0] : r_hdr.header_words;
        l4_start = PW'(ETH_HDR) + PW'({hw_eff, 2'b00});
        rel      = r_pos - l4_start;
        in_l4    = r_pos >= l4_start;

        n_hdr = r_hdr;
        n_pos = r_pos;
        if (keep) begin
            n_pos = r_pos + PW'(1);
            if (r_pos == PW'(POS_ETYPE_HI)) begin
                n_hdr.type_reg[15:8] = i_byte;
            end
            if (r_pos == PW'(POS_ETYPE_LO)) begin
                n_hdr.type_reg[7:0] = i_byte;
            end
            if (r_pos == PW'(POS_IHL)) begin
                n_hdr.header_words = i_byte[3:0];
            end
            if (r_pos == PW'(POS_PROTO)) begin
                n_hdr.proto_reg = i_byte;
            end
            if (r_pos >= PW'(POS_SRC_LO) && r_pos <= PW'(POS_SRC_HI)) begin
                n_hdr.src_addr_reg = {r_hdr.src_addr_reg[23:0], i_byte};
            end
            if (r_pos >= PW'(POS_DST_LO) && r_pos <= PW'(POS_DST_HI)) begin
                n_hdr.dst_addr_reg = {r_hdr.dst_addr_reg[23:0], i_byte};
            end
            if (in_l4) begin
                if (rel <= PW'(L4_PORT_LAST)) begin
                    n_hdr.port_pair_reg = {r_hdr.port_pair_reg[23:0], i_byte};
                end
                if (rel == PW'(L4_OFFS_BYTE)) begin
                    n_hdr.l4_bytes_reg[15:8] = i_byte;
                    n_hdr.tcp_offset_reg     = i_byte[7:4];
                end
                if (rel == PW'(L4_FLAG_BYTE)) begin
                    n_hdr.l4_bytes_reg[7:0] = i_byte;
                end
            end
        end

        o_hdr = n_hdr;
        o_len = (n_pos < limit) ? n_pos : limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_hdr <= '0;
        end else if (i_take) begin
            if (i_last) begin
                r_pos <= '0;
                r_hdr <= '0;
            end else begin
                r_pos <= n_pos;
                r_hdr <= n_hdr;
            end
        end
    end

endmodule

// ===== hdl/ehc_classify.sv =====
// ----------------------------------------------------------------------------
// ehc_classify
// turns the captured header fields of a finished frame into one record
// ----------------------------------------------------------------------------
module ehc_classify #(
    parameter int MAX_FRAME = ehc_pkg::MAX_FRAME_DEF
) (
    input  ehc_pkg::t_ehc_hdr                i_hdr,
    input  logic [$clog2(MAX_FRAME+1)-1:0]   i_len,
    output ehc_pkg::t_ehc_rec                o_rec
);
    import ehc_pkg::*;

    localparam int PW = $clog2(MAX_FRAME + 1);

    logic [PW-1:0] ip_len;
    logic [PW-1:0] ihl;
    logic [PW-1:0] l4_len;
    logic [PW-1:0] tcp_off;
    logic          is_ipv4;

    always_comb begin
        ip_len  = i_len - PW'(ETH_HDR);
        ihl     = PW'({i_hdr.header_words, 2'b00});
        l4_len  = ip_len - ihl;
        tcp_off = PW'({i_hdr.tcp_offset_reg, 2'b00});
        is_ipv4 = (i_hdr.type_reg == ETYPE_IPV4) && (i_len >= PW'(ETH_HDR + IPV4_MIN));

        o_rec              = '0;
        o_rec.packet_class = CLS_SHORT;
        o_rec.frame_length = 12'(i_len);

        if (i_len >= PW'(ETH_HDR)) begin
            o_rec.ether_type = i_hdr.type_reg;
            if (is_ipv4) begin
                o_rec.ip_proto     = i_hdr.proto_reg;
                o_rec.packet_class = CLS_IPV4;
                o_rec.source_ip    = i_hdr.src_addr_reg;
                o_rec.dest_ip      = i_hdr.dst_addr_reg;
                if (i_hdr.proto_reg == PROTO_TCP && ip_len >= ihl + PW'(TCP_MIN)) begin
                    o_rec.packet_class   = CLS_TCP;
                    o_rec.source_port    = i_hdr.port_pair_reg[31:16];
                    o_rec.dest_port      = i_hdr.port_pair_reg[15:0];
                    o_rec.tcp_flag_bits  = i_hdr.l4_bytes_reg[7:0];
                    // data offset past the kept bytes gives no payload
                    o_rec.payload_length = (l4_len > tcp_off) ? 12'(l4_len - tcp_off) : '0;
                end else if (i_hdr.proto_reg == PROTO_UDP &&
                             ip_len >= ihl + PW'(UDP_HDR)) begin
                    o_rec.packet_class   = CLS_UDP;
                    o_rec.source_port    = i_hdr.port_pair_reg[31:16];
                    o_rec.dest_port      = i_hdr.port_pair_reg[15:0];
                    o_rec.payload_length = 12'(l4_len - PW'(UDP_HDR));
                end else if (i_hdr.proto_reg == PROTO_ICMP &&
                             ip_len >= ihl + PW'(UDP_HDR)) begin
                    o_rec.packet_class   = CLS_ICMP;
                    o_rec.icmp_type_code = i_hdr.port_pair_reg[31:24];
                    o_rec.icmp_code_byte = i_hdr.port_pair_reg[23:16];
                    o_rec.payload_length = 12'(l4_len);
                end else begin
                    // layer-4 header missing or unknown protocol: no addresses
                    o_rec.source_ip = '0;
                    o_rec.dest_ip   = '0;
                end
            end else if (i_hdr.type_reg == ETYPE_ARP) begin
                o_rec.packet_class = CLS_ARP;
            end else begin
                o_rec.packet_class = CLS_OTHER;
            end
        end
    end

endmodule

// ===== hdl/ethernet_ipv4_header_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// ethernet_ipv4_header_classifier_unit
// byte-stream ethernet / ipv4 / layer-4 header classifier
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle on the slave stream (tlast on the final
// byte) and emits one classification record per frame on the master stream
// from the output register, after the frame end has passed the capture and
// record stages. Bytes beyond the kept length (snap length, or MAX_FRAME
// when the snap length is zero or larger) are accepted and ignored. The
// input stalls only when a frame end reaches the capture stage while the
// previous record is still held, unread, in both the record stage and the
// output register; otherwise a byte is taken every cycle. Configuration
// writes are always taken and should be made between frames.
module ethernet_ipv4_header_classifier_unit #(
    parameter int MAX_FRAME = ehc_pkg::MAX_FRAME_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // data_byte [7:0]
    input  logic [ehc_pkg::DATA_W-1:0]       s_axis_tdata,
    input  logic                             s_axis_tlast,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // ether_type [15:0], frame_length [27:16], source_ip [59:28],
    // dest_ip [91:60], ip_proto [99:92], source_port [115:100],
    // dest_port [131:116], tcp_flag_bits [139:132], icmp_type_code [147:140],
    // icmp_code_byte [155:148], payload_length [167:156]
    output logic [ehc_pkg::RESULT_W-1:0]     m_axis_tdata,
    // packet_class [2:0]
    output logic [ehc_pkg::CLASS_W-1:0]      m_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // snap_length [11:0]
    input  logic [ehc_pkg::SNAP_W-1:0]       i_cfg_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready
);
    import ehc_pkg::*;

    localparam int PW = $clog2(MAX_FRAME + 1);

    logic [SNAP_W-1:0] r_snap;

    logic              r_s1_valid;
    logic [DATA_W-1:0] r_s1_byte;
    logic              r_s1_last;

    logic              r_s2_valid;
    t_ehc_hdr          r_s2_hdr;
    logic [PW-1:0]     r_s2_len;

    logic              r_out_valid;
    t_ehc_rec          r_out_rec;

    logic              s2_go;
    logic              s2_free;
    logic              s1_go;
    t_ehc_hdr          n_hdr;
    logic [PW-1:0]     n_len;
    t_ehc_rec          n_rec;

    assign s2_go         = r_s2_valid && (!r_out_valid || m_axis_tready);
    assign s2_free       = !r_s2_valid || s2_go;
    // bytes that end no frame never wait on the record path
    assign s1_go         = r_s1_valid && (!r_s1_last || s2_free);
    assign s_axis_tready = !r_s1_valid || s1_go;
    assign o_cfg_ready   = 1'b1;

    ehc_capture #(
        .MAX_FRAME     (MAX_FRAME)
    ) u_capture (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (s1_go),
        .i_byte        (r_s1_byte),
        .i_last        (r_s1_last),
        .i_snap_length (r_snap),
        .o_hdr         (n_hdr),
        .o_len         (n_len)
    );

    ehc_classify #(
        .MAX_FRAME (MAX_FRAME)
    ) u_classify (
        .i_hdr     (r_s2_hdr),
        .i_len     (r_s2_len),
        .o_rec     (n_rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap      <= SNAP_RESET;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_snap <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (s1_go && r_s1_last) begin
                r_s2_valid <= 1'b1;
            end else if (s2_go) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_byte <= s_axis_tdata;
            r_s1_last <= s_axis_tlast;
        end
        if (s1_go && r_s1_last) begin
            r_s2_hdr <= n_hdr;
            r_s2_len <= n_len;
        end
        if (s2_go) begin
            r_out_rec <= n_rec;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_rec.packet_class;
    assign m_axis_tdata  = {r_out_rec.payload_length,
                            r_out_rec.icmp_code_byte,
                            r_out_rec.icmp_type_code,
                            r_out_rec.tcp_flag_bits,
                            r_out_rec.dest_port,
                            r_out_rec.source_port,
                            r_out_rec.ip_proto,
                            r_out_rec.dest_ip,
                            r_out_rec.source_ip,
                            r_out_rec.frame_length,
                            r_out_rec.ether_type};

endmodule

// ===== hdl/ehc_checker.sv =====
// ----------------------------------------------------------------------------
// ehc_checker
// port-level checks for the ethernet ipv4 header classifier
// ----------------------------------------------------------------------------
`include "ethernet_ipv4_header_classifier_unit_macros.svh"

module ehc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ehc_pkg::RESULT_W-1:0]     m_axis_tdata,
    input logic [ehc_pkg::CLASS_W-1:0]      m_axis_tuser
);
    import ehc_pkg::*;

    logic non_ip;
    logic short_ok;
    logic l3_zero;

    assign non_ip   = (m_axis_tuser == CLS_SHORT) || (m_axis_tuser == CLS_ARP) ||
                      (m_axis_tuser == CLS_OTHER);
    // short frames carry no ethertype and fewer than a full ethernet header
    assign short_ok = (m_axis_tdata[15:0] == '0) && (m_axis_tdata[27:16] < 12'(ETH_HDR));
    // addresses, protocol, ports, flags, icmp bytes and payload length all zero
    assign l3_zero  = (m_axis_tdata[RESULT_W-1:28] == '0);

    `EHC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "record changed while stalled")
    `EHC_ASSERT_IMP(a_class_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser <= CLS_OTHER, "unknown packet class")
    `EHC_ASSERT_IMP(a_short_frame, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == CLS_SHORT), short_ok, "short frame record malformed")
    `EHC_ASSERT_IMP(a_non_ip_zero, i_clk, i_rst_n, m_axis_tvalid && non_ip, l3_zero, "non-ip record has layer-3 fields")

endmodule

bind ethernet_ipv4_header_classifier_unit ehc_checker u_ehc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
